// ===== rtl/mtf_pkg.sv =====
// Shared types and constants for the move-to-front transform core.
// Used by mtf_cell, mtf_group and move_to_front_transform_core. No dependencies.
package mtf_pkg;

  localparam int unsigned ALPHABET_SIZE = 256;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned POS_W         = 8;
  localparam int unsigned GROUP_SIZE    = 16;
  localparam int unsigned GRP_W         = $clog2(GROUP_SIZE);
  localparam int unsigned NUM_GROUPS    = (ALPHABET_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned GID_W         = POS_W - GRP_W;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_DECODE_MODE = 1'b0;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [GROUP_SIZE-1:0][SYM_W-1:0] grp_syms_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic load_id;   // restore identity order
    logic shift;     // move-to-front shift of cells 0..pos
    logic decode;    // compare index instead of content
    sym_t key;       // symbol (encode) or saturated position (decode)
    pos_t pos;       // shift boundary
    sym_t front_sym; // symbol entering cell 0
  } cell_ctrl_t;

  // registered result of one group encoder
  typedef struct packed {
    logic             hit;
    logic [GRP_W-1:0] lo;
    sym_t             sym;
  } grp_res_t;

endpackage

// ===== rtl/move_to_front_transform_core.sv =====
// Move-to-front transform core: cell chain, group encoders, sequencer, APB regs.
// Depends on mtf_pkg, mtf_cell, mtf_group.
//
//  Port group | Handshake          | Payload
//  -----------+--------------------+------------------------------------------
//  in_        | in_valid/in_ready  | in_data_in[7:0], in_stream_start
//  out_       | out_valid/out_ready| out_data_out[7:0]
//  cfg_       | APB (pready tied 1)| decode_mode at byte address 0, bit 0
//
// Each word passes these steps in order: accept (and identity reload on
// stream start), cell compare, group encode, final encode, shift. The encode
// tree across the 256 cells sets the number of steps. Reset restores the
// identity list and encode mode. A result waiting on out_ready stalls only the
// shift step; the next word may be accepted while the output word waits.
module move_to_front_transform_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_in,
  input  logic                       in_stream_start,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_data_out,
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [mtf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mtf_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [mtf_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import mtf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_GRP  = 5'b00100,
    ST_SEL  = 5'b01000,
    ST_MOVE = 5'b10000
  } state_t;

  // ---------------- configuration ----------------
  logic decode_mode_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
    end else if (cfg_wr && (cfg_paddr[2] == REG_DECODE_MODE)) begin
      decode_mode_r <= cfg_pwdata[0];
    end
  end

  // unused low address bits select nothing; registers are word aligned
  assign cfg_prdata = (cfg_paddr[2] == REG_DECODE_MODE) ?
                      {{(CFG_DW-1){1'b0}}, decode_mode_r} : '0;

  // ---------------- sequencer ----------------
  state_t state_r, state_nxt;
  sym_t   key_r;        // latched search key
  pos_t   pos_r;        // matched position
  sym_t   sel_sym_r;    // symbol at matched position
  logic   found_r;
  logic   out_valid_r;
  sym_t   out_data_r;
  logic   in_acc;
  logic   out_free;
  logic   move_go;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;
  assign move_go  = (state_r == ST_MOVE) & out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_GRP;
      ST_GRP:  state_nxt = ST_SEL;
      ST_SEL:  state_nxt = ST_MOVE;
      ST_MOVE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // decode positions past the alphabet saturate to the last entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (decode_mode_r && (int'(in_data_in) >= ALPHABET_SIZE)) begin
        key_r <= SYM_W'(ALPHABET_SIZE - 1);
      end else begin
        key_r <= in_data_in;
      end
    end
  end

  // ---------------- cell chain ----------------
  cell_ctrl_t             ctrl;
  grp_syms_t              cell_sym   [NUM_GROUPS];
  logic [GROUP_SIZE-1:0]  cell_match [NUM_GROUPS];
  grp_res_t               grp_res    [NUM_GROUPS];

  always_comb begin
    ctrl.load_id   = in_acc & in_stream_start;
    ctrl.shift     = move_go & found_r;
    ctrl.decode    = decode_mode_r;
    ctrl.key       = key_r;
    ctrl.pos       = pos_r;
    ctrl.front_sym = sel_sym_r;
  end

  for (genvar i = 0; i < NUM_GROUPS * GROUP_SIZE; i++) begin : g_cell
    if (i < ALPHABET_SIZE) begin : g_real
      sym_t shift_in;
      if (i == 0) begin : g_head
        assign shift_in = ctrl.front_sym;
      end else begin : g_link
        assign shift_in = cell_sym[(i-1) / GROUP_SIZE][(i-1) % GROUP_SIZE];
      end
      mtf_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (POS_W'(i)),
        .ctrl     (ctrl),
        .shift_in (shift_in),
        .sym_o    (cell_sym[i / GROUP_SIZE][i % GROUP_SIZE]),
        .match_o  (cell_match[i / GROUP_SIZE][i % GROUP_SIZE])
      );
    end else begin : g_pad
      // slots past the alphabet never match
      assign cell_sym[i / GROUP_SIZE][i % GROUP_SIZE]   = '0;
      assign cell_match[i / GROUP_SIZE][i % GROUP_SIZE] = 1'b0;
    end
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    mtf_group u_group (
      .clk       (clk),
      .grp_match (cell_match[g]),
      .grp_sym   (cell_sym[g]),
      .grp_res   (grp_res[g])
    );
  end

  // ---------------- final encode ----------------
  logic found_nxt;
  pos_t pos_nxt;
  sym_t sel_sym_nxt;

  always_comb begin
    found_nxt   = 1'b0;
    pos_nxt     = '0;
    sel_sym_nxt = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (grp_res[g].hit) begin
        found_nxt   = 1'b1;
        pos_nxt     = pos_nxt | {GID_W'(g), grp_res[g].lo};
        sel_sym_nxt = sel_sym_nxt | grp_res[g].sym;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SEL) begin
      found_r   <= found_nxt;
      pos_r     <= pos_nxt;
      sel_sym_r <= sel_sym_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // encode miss (symbol outside the alphabet) gives position 0
  always_ff @(posedge clk) begin
    if (move_go) begin
      if (decode_mode_r) begin
        out_data_r <= sel_sym_r;
      end else begin
        out_data_r <= found_r ? pos_r : '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

endmodule

// ===== rtl/mtf_cell.sv =====
// One list entry of the move-to-front chain: holds a symbol, compares, shifts.
// Depends on mtf_pkg.
module mtf_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  mtf_pkg::pos_t      cell_idx,
  input  mtf_pkg::cell_ctrl_t ctrl,
  input  mtf_pkg::sym_t      shift_in,
  output mtf_pkg::sym_t      sym_o,
  output logic               match_o
);
  import mtf_pkg::*;

  sym_t sym_r;
  logic match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r <= cell_idx;
    end else if (ctrl.load_id) begin
      sym_r <= cell_idx;
    end else if (ctrl.shift && (cell_idx <= ctrl.pos)) begin
      sym_r <= shift_in;
    end
  end

  // decode: the cell at the requested position; encode: the cell holding the symbol
  always_ff @(posedge clk) begin
    match_r <= ctrl.decode ? (cell_idx == ctrl.key) : (sym_r == ctrl.key);
  end

  assign sym_o   = sym_r;
  assign match_o = match_r;

endmodule

// ===== rtl/mtf_group.sv =====
// Registered one-hot encoder over one group of cells: hit, local index, symbol.
// Depends on mtf_pkg.
module mtf_group (
  input  logic                          clk,
  input  logic [mtf_pkg::GROUP_SIZE-1:0] grp_match,
  input  mtf_pkg::grp_syms_t            grp_sym,
  output mtf_pkg::grp_res_t             grp_res
);
  import mtf_pkg::*;

  grp_res_t res_nxt;
  grp_res_t res_r;

  // at most one match in the list, so plain OR-reduction suffices
  always_comb begin
    res_nxt = '0;
    for (int j = 0; j < GROUP_SIZE; j++) begin
      if (grp_match[j]) begin
        res_nxt.hit = 1'b1;
        res_nxt.lo  = res_nxt.lo | GRP_W'(j);
        res_nxt.sym = res_nxt.sym | grp_sym[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign grp_res = res_r;

endmodule
